FILE: sv/mts_pkg.sv
package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

    localparam int FIELD_BITS  = 32;
    localparam int OCC_BITS    = 7;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef logic [VALUE_BITS-1:0] word_t;

    // Shift command shared by every cell of one chain.
    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

endpackage

FILE: sv/mts_cmd_if.sv
interface mts_cmd_if;
    import mts_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic signed [FIELD_BITS-1:0] push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface

FILE: sv/mts_rsp_if.sv
interface mts_rsp_if;
    import mts_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] top_value;
    logic signed [FIELD_BITS-1:0] min_value;
    logic                         is_empty;
    logic [OCC_BITS-1:0]          occupancy;
    status_t                      status;

    modport source (output valid, output top_value, output min_value, output is_empty,
                    output occupancy, output status, input ready);
    modport sink   (input valid, input top_value, input min_value, input is_empty,
                    input occupancy, input status, output ready);
endinterface

FILE: sv/mts_cell.sv
module mts_cell (
    input  logic            clk,
    input  mts_pkg::shift_t ctrl,
    input  mts_pkg::word_t  from_above,
    input  mts_pkg::word_t  from_below,
    output mts_pkg::word_t  value
);
    import mts_pkg::*;

    word_t value_reg;
    word_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.push)
        begin
            value_next = from_above;
        end
        else if (ctrl.pop)
        begin
            value_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
endmodule

FILE: sv/mts_chain.sv
module mts_chain (
    input  logic            clk,
    input  mts_pkg::shift_t ctrl,
    input  mts_pkg::word_t  load_value,
    output mts_pkg::word_t  first,
    output mts_pkg::word_t  second
);
    import mts_pkg::*;

    // Cell zero is the top of the stack; a push moves every entry one cell deeper.
    word_t taps [STACK_DEPTH];

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        word_t above;
        word_t below;

        if (i == 0)
        begin : g_head
            assign above = load_value;
        end
        else
        begin : g_body
            assign above = taps[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_tail
            assign below = '0;
        end
        else
        begin : g_inner
            assign below = taps[i+1];
        end

        mts_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .from_above (above),
            .from_below (below),
            .value      (taps[i])
        );
    end

    assign first  = taps[0];
    assign second = taps[1];
endmodule

FILE: sv/min_tracking_stack_unit.sv
// Channel  Role    Payload
// cmd      sink    kind, push_value
// rsp      source  top_value, min_value, is_empty, occupancy, status
//
// One command beat is taken per cycle while the response register is free or draining,
// and its response beat appears in the next cycle. Both stacks are rows of cells that
// shift by one place per beat, so only the top two cells of each row are ever looked at.
// A stalled response holds the command side only while the response register is full.
// Reset clears the counts and the response valid; cell contents are left as they are.
module min_tracking_stack_unit (
    input  logic       clk,
    input  logic       rst_n,
    mts_cmd_if.sink    cmd,
    mts_rsp_if.source  rsp
);
    import mts_pkg::*;

    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic [COUNT_BITS-1:0] min_cnt_reg;
    logic [COUNT_BITS-1:0] min_cnt_next;

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic [FIELD_BITS-1:0] top_reg;
    logic [FIELD_BITS-1:0] top_next;
    logic [FIELD_BITS-1:0] min_reg;
    logic [FIELD_BITS-1:0] min_next;
    logic                  empty_reg;
    logic                  empty_next;
    logic [OCC_BITS-1:0]   occ_reg;
    logic [OCC_BITS-1:0]   occ_next;
    status_t               status_reg;
    status_t               status_next;

    word_t  kept;
    word_t  val_top;
    word_t  val_second;
    word_t  min_top;
    word_t  min_second;
    word_t  new_top;
    word_t  new_min;
    shift_t val_ctrl;
    shift_t min_ctrl;

    logic fire;
    logic is_push;
    logic full;
    logic empty;
    logic push_ok;
    logic pop_ok;
    logic take;
    logic min_match;

    assign kept = VALUE_BITS'(cmd.push_value);

    mts_chain u_value_chain (
        .clk        (clk),
        .ctrl       (val_ctrl),
        .load_value (kept),
        .first      (val_top),
        .second     (val_second)
    );

    mts_chain u_min_chain (
        .clk        (clk),
        .ctrl       (min_ctrl),
        .load_value (kept),
        .first      (min_top),
        .second     (min_second)
    );

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = cmd.valid && cmd.ready;
    assign is_push   = (cmd.kind == KIND_PUSH);
    assign full      = (cnt_reg == COUNT_BITS'(STACK_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign push_ok   = is_push && !full;
    assign pop_ok    = !is_push && !empty;
    assign take      = (min_cnt_reg == '0) || ($signed(kept) <= $signed(min_top));
    assign min_match = (min_cnt_reg != '0) && (min_top == val_top);

    always_comb
    begin
        val_ctrl.push = fire && push_ok;
        val_ctrl.pop  = fire && pop_ok;
        min_ctrl.push = fire && push_ok && take;
        min_ctrl.pop  = fire && pop_ok && min_match;

        cnt_next     = cnt_reg;
        min_cnt_next = min_cnt_reg;
        if (val_ctrl.push)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (val_ctrl.pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        if (min_ctrl.push)
        begin
            min_cnt_next = min_cnt_reg + 1'b1;
        end
        else if (min_ctrl.pop)
        begin
            min_cnt_next = min_cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        if (push_ok)
        begin
            new_top = kept;
        end
        else if (pop_ok)
        begin
            new_top = val_second;
        end
        else
        begin
            new_top = val_top;
        end

        if (push_ok && take)
        begin
            new_min = kept;
        end
        else if (pop_ok && min_match)
        begin
            new_min = min_second;
        end
        else
        begin
            new_min = min_top;
        end

        if (cnt_next == '0)
        begin
            new_top = '0;
        end
        if (cnt_next == '0 || min_cnt_next == '0)
        begin
            new_min = '0;
        end

        if (is_push && full)
        begin
            status_next = STATUS_FULL;
        end
        else if (!is_push && empty)
        begin
            status_next = STATUS_EMPTY;
        end
        else
        begin
            status_next = STATUS_DONE;
        end

        top_next   = FIELD_BITS'($unsigned(new_top));
        min_next   = FIELD_BITS'($unsigned(new_min));
        empty_next = (cnt_next == '0);
        occ_next   = OCC_BITS'(cnt_next);

        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            min_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            min_cnt_reg   <= min_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            top_reg    <= top_next;
            min_reg    <= min_next;
            empty_reg  <= empty_next;
            occ_reg    <= occ_next;
            status_reg <= status_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.top_value = top_reg;
    assign rsp.min_value = min_reg;
    assign rsp.is_empty  = empty_reg;
    assign rsp.occupancy = occ_reg;
    assign rsp.status    = status_reg;

    // The minima stack never holds more entries than the value stack.
    assert property (@(posedge clk) disable iff (!rst_n) min_cnt_reg <= cnt_reg)
        else $error("minima count exceeds value count");

    // Any held entry implies a tracked minimum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (min_cnt_reg != '0))
        else $error("stack holds entries but minima stack is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= COUNT_BITS'(STACK_DEPTH))
        else $error("value count exceeds depth");

    // A refused command leaves both counts unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !push_ok && !pop_ok) |=> ($stable(cnt_reg) && $stable(min_cnt_reg)))
        else $error("refused command changed a count");

    // A new response beat is presented in the cycle after each accepted command.
    assert property (@(posedge clk) disable iff (!rst_n) fire |=> rsp_valid_reg)
        else $error("accepted command produced no response");
endmodule

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [FIELD_BITS-1:0] top_value;
        logic signed [FIELD_BITS-1:0] min_value;
        logic                         is_empty;
        logic [OCC_BITS-1:0]          occupancy;
        status_t                      status;
    } stack_report_t;

    logic clk = 1'b0;
    logic rst_n;

    bit    steady;
    int    mismatch_count;
    int    cycle_count;
    int    ready_hold;

    word_t value_stack [STACK_DEPTH];
    word_t min_stack [STACK_DEPTH];
    int    value_depth;
    int    min_depth;

    stack_report_t pending_reports [$];

    mts_cmd_if cmd_if ();
    mts_rsp_if rsp_if ();

    min_tracking_stack_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    function automatic stack_report_t compute_stack_report(logic kind, word_t value);
        stack_report_t rpt;
        rpt.status = STATUS_DONE;
        if (kind == KIND_PUSH)
        begin
            if (value_depth == STACK_DEPTH)
            begin
                rpt.status = STATUS_FULL;
            end
            else
            begin
                if (min_depth == 0 || $signed(value) <= $signed(min_stack[min_depth-1]))
                begin
                    min_stack[min_depth] = value;
                    min_depth++;
                end
                value_stack[value_depth] = value;
                value_depth++;
            end
        end
        else
        begin
            if (value_depth == 0)
            begin
                rpt.status = STATUS_EMPTY;
            end
            else
            begin
                if (min_depth > 0 && min_stack[min_depth-1] == value_stack[value_depth-1])
                begin
                    min_depth--;
                end
                value_depth--;
            end
        end
        if (value_depth > 0)
        begin
            rpt.top_value = value_stack[value_depth-1];
            rpt.min_value = (min_depth > 0) ? min_stack[min_depth-1] : '0;
        end
        else
        begin
            rpt.top_value = '0;
            rpt.min_value = '0;
        end
        rpt.is_empty  = (value_depth == 0);
        rpt.occupancy = OCC_BITS'(value_depth);
        return rpt;
    endfunction

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
        begin
            return 0;
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Values are drawn near the current minimum and top often enough that
    // ties and new minima are frequent.
    function automatic word_t pick_value();
        word_t near;
        near = '0;
        if (min_depth > 0)
        begin
            near = min_stack[min_depth-1];
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return word_t'($urandom_range(0, 16)) - 32'd8;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            8:       return near + word_t'($urandom_range(0, 2)) - 32'd1;
            default: return (value_depth > 0) ? value_stack[value_depth-1] : $urandom();
        endcase
    endfunction

    task automatic issue_op(logic kind, word_t value);
        int idle;
        idle = idle_cycles();
        if (idle > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.kind       <= kind;
        cmd_if.push_value <= value;
        @(posedge clk);
        while (cmd_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        pending_reports.push_back(compute_stack_report(kind, value));
        @(negedge clk);
    endtask

    task automatic test_empty_pop();
        issue_op(KIND_POP, 32'h0000_0000);
        issue_op(KIND_POP, 32'hffff_ffff);
    endtask

    task automatic test_value_extremes();
        issue_op(KIND_PUSH, 32'h7fff_ffff);
        issue_op(KIND_PUSH, 32'h8000_0000);
        issue_op(KIND_PUSH, 32'h0000_0000);
        issue_op(KIND_PUSH, 32'hffff_ffff);
        issue_op(KIND_POP, 32'h5555_5555);
        issue_op(KIND_POP, 32'haaaa_aaaa);
        issue_op(KIND_POP, 32'h0000_0000);
        issue_op(KIND_POP, 32'h0000_0000);
        issue_op(KIND_POP, 32'h0000_0000);
    endtask

    task automatic test_equal_minimum();
        issue_op(KIND_PUSH, 32'd5);
        issue_op(KIND_PUSH, 32'd3);
        issue_op(KIND_PUSH, 32'd3);
        issue_op(KIND_PUSH, 32'd9);
        issue_op(KIND_PUSH, 32'd3);
        repeat (5) issue_op(KIND_POP, '0);
    endtask

    task automatic test_full_refusal();
        while (value_depth < STACK_DEPTH)
        begin
            issue_op(KIND_PUSH, pick_value());
        end
        repeat (3) issue_op(KIND_PUSH, pick_value());
        repeat (2) issue_op(KIND_POP, pick_value());
        repeat (3) issue_op(KIND_PUSH, pick_value());
    endtask

    task automatic test_random_walk(int ops, int push_pct, bit no_idle);
        logic kind;
        steady = no_idle;
        repeat (ops)
        begin
            kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
            issue_op(kind, pick_value());
        end
        steady = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (steady)
        begin
            rsp_if.ready <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            ready_hold--;
        end
        else if (rsp_if.ready)
        begin
            ready_hold = idle_cycles();
            if (ready_hold > 0)
            begin
                rsp_if.ready <= 1'b0;
                ready_hold--;
            end
            else
            begin
                ready_hold = $urandom_range(0, 8);
            end
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            ready_hold = $urandom_range(0, 8);
        end
    end

    always @(posedge clk)
    begin
        stack_report_t exp_rpt;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("unexpected response beat");
                mismatch_count++;
            end
            else
            begin
                exp_rpt = pending_reports.pop_front();
                if (rsp_if.top_value !== exp_rpt.top_value)
                begin
                    $error("top_value: expected %0d, actual %0d",
                           exp_rpt.top_value, rsp_if.top_value);
                    mismatch_count++;
                end
                if (rsp_if.min_value !== exp_rpt.min_value)
                begin
                    $error("min_value: expected %0d, actual %0d",
                           exp_rpt.min_value, rsp_if.min_value);
                    mismatch_count++;
                end
                if (rsp_if.is_empty !== exp_rpt.is_empty)
                begin
                    $error("is_empty: expected %0d, actual %0d",
                           exp_rpt.is_empty, rsp_if.is_empty);
                    mismatch_count++;
                end
                if (rsp_if.occupancy !== exp_rpt.occupancy)
                begin
                    $error("occupancy: expected %0d, actual %0d",
                           exp_rpt.occupancy, rsp_if.occupancy);
                    mismatch_count++;
                end
                if (rsp_if.status !== exp_rpt.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           exp_rpt.status, rsp_if.status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("min_tracking_stack_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.kind       = KIND_PUSH;
        cmd_if.push_value = '0;
        rsp_if.ready      = 1'b1;
        ready_hold        = 0;
        steady            = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;
        value_depth       = 0;
        min_depth         = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_pop();
        test_value_extremes();
        test_equal_minimum();
        test_full_refusal();
        test_random_walk(450, 50, 1'b0);
        test_random_walk(350, 80, 1'b0);
        test_random_walk(350, 20, 1'b0);
        test_random_walk(300, 60, 1'b1);
        test_random_walk(400, 45, 1'b0);

        cmd_if.valid <= 1'b0;
        wait (pending_reports.size() == 0);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
        begin
            $display("min_tracking_stack_unit: match");
        end
        else
        begin
            $display("min_tracking_stack_unit: mismatch");
        end
        $finish;
    end

endmodule
